@@ hw/rtl/qpht_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qpht_pkg: shared definitions for the quadratic probe hash table
// Table geometry, field widths, status codes and the inter-module structs.
// ----------------------------------------------------------------------------
package qpht_pkg;

  // table geometry, size must be a power of two (home slot is a bit mask)
  localparam int TableSize = 16;
  localparam int IdxW      = (TableSize > 1) ? $clog2(TableSize) : 1;
  localparam int CntW      = IdxW + 1;

  // payload widths
  localparam int KeyW = 31;
  localparam int ValW = 32;

  // operation codes of the mode field
  localparam logic ModeInsert = 1'b0;
  localparam logic ModeSearch = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_INSERTED  = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_FOUND     = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_e;

  // probe address generator to sequencer
  typedef struct packed {
    logic            issue;
    logic            last;
    logic [IdxW-1:0] slot;
  } probe_t;

  // sequencer to slot store write port
  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } wr_req_t;

endpackage

`default_nettype wire

@@ hw/rtl/qpht_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qpht_store: slot store of the hash table
// Used bits in flops cleared by reset, key and value in a memory with one
// registered read port and one write port.
// ----------------------------------------------------------------------------
module qpht_store (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               rd_en_i,
  input  wire  [qpht_pkg::IdxW-1:0]         rd_addr_i,
  output logic                              used_o,
  output logic [qpht_pkg::KeyW-1:0]         rd_key_o,
  output logic [qpht_pkg::ValW-1:0]         rd_value_o,
  input  wire  qpht_pkg::wr_req_t           wr_req_i
);

  logic [qpht_pkg::TableSize-1:0] used_q;
  logic [qpht_pkg::KeyW-1:0]      key_mem [qpht_pkg::TableSize];
  logic [qpht_pkg::ValW-1:0]      value_mem [qpht_pkg::TableSize];
  logic [qpht_pkg::KeyW-1:0]      rd_key_q;
  logic [qpht_pkg::ValW-1:0]      rd_value_q;

  // used bits, all slots empty after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (wr_req_i.en) begin
      used_q[wr_req_i.addr] <= 1'b1;
    end
  end

  assign used_o = used_q[rd_addr_i];

  // key and value memory write
  always_ff @(posedge clk_i) begin
    if (wr_req_i.en) begin
      key_mem[wr_req_i.addr]   <= wr_req_i.key;
      value_mem[wr_req_i.addr] <= wr_req_i.value;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_key_q   <= key_mem[rd_addr_i];
      rd_value_q <= value_mem[rd_addr_i];
    end
  end

  assign rd_key_o   = rd_key_q;
  assign rd_value_o = rd_value_q;

endmodule

`default_nettype wire

@@ hw/rtl/qpht_probe_gen.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qpht_probe_gen: quadratic probe address generator
// Keeps i*i mod size incrementally with an adder (adds 2i+1 per
// probe) and forms the slot address home + i*i mod size.
// ----------------------------------------------------------------------------
module qpht_probe_gen (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire  [qpht_pkg::IdxW-1:0]    home_i,
  input  wire                          step_i,
  output qpht_pkg::probe_t             probe_o
);

  logic [qpht_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [qpht_pkg::IdxW-1:0] sq_q, sq_d;
  logic [qpht_pkg::IdxW-1:0] home_q, home_d;
  logic [qpht_pkg::IdxW:0]   inc;
  logic                      issue;

  // probes remain while fewer than table size have been issued
  assign issue = (cnt_q < qpht_pkg::CntW'(qpht_pkg::TableSize));
  assign inc   = {cnt_q[qpht_pkg::IdxW-1:0], 1'b1};

  // next probe square offset and count
  always_comb begin
    cnt_d  = cnt_q;
    sq_d   = sq_q;
    home_d = home_q;
    if (start_i) begin
      cnt_d  = '0;
      sq_d   = '0;
      home_d = home_i;
    end else if (step_i && issue) begin
      cnt_d = cnt_q + qpht_pkg::CntW'(1);
      sq_d  = sq_q + inc[qpht_pkg::IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= qpht_pkg::CntW'(qpht_pkg::TableSize);
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q   <= sq_d;
    home_q <= home_d;
  end

  // slot address wraps modulo the table size
  assign probe_o.issue = issue;
  assign probe_o.last  = (cnt_q == qpht_pkg::CntW'(qpht_pkg::TableSize - 1));
  assign probe_o.slot  = home_q + sq_q;

endmodule

`default_nettype wire

@@ hw/rtl/quadratic_probe_hash_table_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table_top: open-addressed table, quadratic probing
// Probing: p (1 .. TableSize) is the number of probes, one probe per cycle;
//   the result is registered in the output register after the last check.
// Flow: one item at a time, set by the probe loop over the
//   single read port of the slot store; input stalls while an item runs.
// Reset: rst_ni clears all used bits at once, every slot empty, no sweep.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table_top (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire                                  mode_i,
  input  wire  [qpht_pkg::KeyW-1:0]            key_i,
  input  wire  signed [qpht_pkg::ValW-1:0]     value_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic [1:0]                           status_o,
  output logic signed [qpht_pkg::ValW-1:0]     found_value_o
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_PROBE = 2'b10
  } state_e;

  state_e                    state_q, state_d;
  logic                      mode_q;
  logic [qpht_pkg::KeyW-1:0] key_q;
  logic [qpht_pkg::ValW-1:0] value_q;

  // check stage registers
  logic                      chk_vld_q;
  logic                      chk_used_q;
  logic                      chk_last_q;
  logic [qpht_pkg::IdxW-1:0] chk_slot_q;

  // output register
  logic                      out_valid_q;
  qpht_pkg::status_e         out_status_q;
  logic [qpht_pkg::ValW-1:0] out_value_q;

  logic                      accept;
  logic                      start;
  logic                      match;
  logic                      done;
  logic                      out_free;
  logic                      advance;
  logic                      issue_step;
  qpht_pkg::status_e         res_status;
  logic                      used_rd;
  logic [qpht_pkg::KeyW-1:0] rd_key;
  logic [qpht_pkg::ValW-1:0] rd_value;
  qpht_pkg::probe_t          probe;
  qpht_pkg::wr_req_t         wr_req;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign start      = accept;

  // probe check: empty slot, key hit on search, or path exhausted
  assign match    = (mode_q == qpht_pkg::ModeSearch) && chk_used_q && (rd_key == key_q);
  assign done     = (state_q == ST_PROBE) && chk_vld_q && (!chk_used_q || match || chk_last_q);
  assign out_free = !out_valid_q || !out_stall_i;
  assign advance  = (state_q == ST_PROBE) && !(done && !out_free);
  assign issue_step = advance && probe.issue && !done;

  // result status of the finishing probe
  always_comb begin
    if (mode_q == qpht_pkg::ModeInsert) begin
      res_status = chk_used_q ? qpht_pkg::STATUS_FULL : qpht_pkg::STATUS_INSERTED;
    end else begin
      res_status = match ? qpht_pkg::STATUS_FOUND : qpht_pkg::STATUS_NOT_FOUND;
    end
  end

  // insert writes the first empty slot on the path
  always_comb begin
    wr_req.en    = done && out_free && (mode_q == qpht_pkg::ModeInsert) && !chk_used_q;
    wr_req.addr  = chk_slot_q;
    wr_req.key   = key_q;
    wr_req.value = value_q;
  end

  qpht_probe_gen u_probe_gen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .home_i  (key_i[qpht_pkg::IdxW-1:0]),
    .step_i  (issue_step),
    .probe_o (probe)
  );

  qpht_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (issue_step),
    .rd_addr_i  (probe.slot),
    .used_o     (used_rd),
    .rd_key_o   (rd_key),
    .rd_value_o (rd_value),
    .wr_req_i   (wr_req)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_PROBE;
      end
      ST_PROBE: begin
        if (done && out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // operand capture on the input beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_i;
      key_q   <= key_i;
      value_q <= value_i;
    end
  end

  // check stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_vld_q <= 1'b0;
    end else if (start || (done && out_free)) begin
      chk_vld_q <= 1'b0;
    end else if (advance) begin
      chk_vld_q <= issue_step;
    end
  end

  // check stage payload follows the issued probe
  always_ff @(posedge clk_i) begin
    if (issue_step) begin
      chk_used_q <= used_rd;
      chk_last_q <= probe.last;
      chk_slot_q <= probe.slot;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (done && out_free) begin
      out_status_q <= res_status;
      out_value_q  <= match ? rd_value : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_value_o = out_value_q;

endmodule

`default_nettype wire
